### hdl/ookd_pkg.sv
// shared types and constants for the four-pulse ook bit decoder
package ookd_pkg;

    localparam int unsigned PULSE_W = 16;
    localparam int unsigned BITS_W  = 7;
    localparam int unsigned CODE_W  = 64;
    localparam int unsigned TAG_W   = 8;
    localparam int unsigned PCT_W   = 7;
    // short/long time times percent, 65535 * 127 fits
    localparam int unsigned PROD_W  = 23;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned WDATA_W = 16;
    localparam int unsigned PCT_DIV = 100;

    // register indexes on the write port
    localparam logic [IDX_W-1:0] IDX_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SHORT  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_LONG   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_TOL    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_TAG    = 3'd4;

    // reset values of the registers
    localparam logic [BITS_W-1:0]  RST_TARGET = 7'd32;
    localparam logic [PULSE_W-1:0] RST_SHORT  = 16'd275;
    localparam logic [PULSE_W-1:0] RST_LONG   = 16'd1375;
    localparam logic [PCT_W-1:0]   RST_TOL    = 7'd20;
    localparam logic [TAG_W-1:0]   RST_TAG    = 8'd0;
    localparam logic [PROD_W-1:0]  RST_PROD_S = 23'd5500;
    localparam logic [PROD_W-1:0]  RST_PROD_L = 23'd27500;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [BITS_W-1:0]  target_bits;
        logic [PULSE_W-1:0] short_time;
        logic [PULSE_W-1:0] long_time;
        logic [PROD_W-1:0]  prod_short;
        logic [PROD_W-1:0]  prod_long;
        logic [TAG_W-1:0]   tag;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic               status;
        logic [CODE_W-1:0]  code;
        logic [BITS_W-1:0]  bits;
        logic [TAG_W-1:0]   tag;
    } res_t;

    // |d - t| < floor(prod / 100)  <=>  100 * (|d - t| + 1) <= prod
    function automatic logic near_time(input logic [PULSE_W-1:0] d,
                                       input logic [PULSE_W-1:0] t,
                                       input logic [PROD_W-1:0]  prod);
        logic [PULSE_W-1:0] diff;
        logic [PULSE_W:0]   diff_p1;
        logic [PROD_W:0]    lhs;
        diff    = (d > t) ? (d - t) : (t - d);
        diff_p1 = {1'b0, diff} + 17'd1;
        lhs     = (PROD_W+1)'(diff_p1) * (PROD_W+1)'(PCT_DIV);
        return lhs <= {1'b0, prod};
    endfunction

endpackage

### hdl/ookd_cfg.sv
// configuration registers and tolerance products
module ookd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [ookd_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ookd_pkg::WDATA_W-1:0] cfg_wdata,
    output ookd_pkg::cfg_t              cfg
);
    import ookd_pkg::*;

    logic [BITS_W-1:0]  target_reg;
    logic [PULSE_W-1:0] short_reg, short_next;
    logic [PULSE_W-1:0] long_reg, long_next;
    logic [PCT_W-1:0]   tol_reg, tol_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [PROD_W-1:0]  prod_s_reg, prod_s_next;
    logic [PROD_W-1:0]  prod_l_reg, prod_l_next;

    // products follow the new register values in the same cycle as the write
    always_comb begin
        short_next = (cfg_we && cfg_index == IDX_SHORT) ? cfg_wdata : short_reg;
        long_next  = (cfg_we && cfg_index == IDX_LONG)  ? cfg_wdata : long_reg;
        tol_next   = (cfg_we && cfg_index == IDX_TOL)   ? cfg_wdata[PCT_W-1:0] : tol_reg;
        prod_s_next = PROD_W'(short_next) * PROD_W'(tol_next);
        prod_l_next = PROD_W'(long_next) * PROD_W'(tol_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= RST_TARGET;
            short_reg  <= RST_SHORT;
            long_reg   <= RST_LONG;
            tol_reg    <= RST_TOL;
            tag_reg    <= RST_TAG;
            prod_s_reg <= RST_PROD_S;
            prod_l_reg <= RST_PROD_L;
        end else begin
            short_reg  <= short_next;
            long_reg   <= long_next;
            tol_reg    <= tol_next;
            prod_s_reg <= prod_s_next;
            prod_l_reg <= prod_l_next;
            if (cfg_we && cfg_index == IDX_TARGET) begin
                target_reg <= cfg_wdata[BITS_W-1:0];
            end
            if (cfg_we && cfg_index == IDX_TAG) begin
                tag_reg <= cfg_wdata[TAG_W-1:0];
            end
        end
    end

    assign cfg.target_bits = target_reg;
    assign cfg.short_time  = short_reg;
    assign cfg.long_time   = long_reg;
    assign cfg.prod_short  = prod_s_reg;
    assign cfg.prod_long   = prod_l_reg;
    assign cfg.tag         = tag_reg;

endmodule

### hdl/ookd_dec.sv
// capture state and group decode, one pulse per cycle while step is high
module ookd_dec (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [ookd_pkg::PULSE_W-1:0] pulse,
    input  logic                         last,
    input  ookd_pkg::cfg_t               cfg,
    output ookd_pkg::res_t               res
);
    import ookd_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [PULSE_W-1:0] held_reg [3];
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic               halted_reg, halted_next;
    logic               rep_reg, rep_next;
    logic               active;
    logic               hi_ok, bit0, bit1;

    always_comb begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        bits_next   = bits_reg;
        halted_next = halted_reg;
        rep_next    = rep_reg;
        res         = '0;
        res.tag     = cfg.tag;
        res.bits    = bits_reg;

        active = !rep_reg && !halted_reg && (bits_reg < cfg.target_bits);
        hi_ok  = near_time(held_reg[0], cfg.short_time, cfg.prod_short) &&
                 near_time(held_reg[2], cfg.short_time, cfg.prod_short);
        bit0   = near_time(held_reg[1], cfg.short_time, cfg.prod_short) &&
                 near_time(pulse, cfg.long_time, cfg.prod_long);
        bit1   = near_time(held_reg[1], cfg.long_time, cfg.prod_long) &&
                 near_time(pulse, cfg.short_time, cfg.prod_short);

        if (step) begin
            if (active) begin
                if (phase_reg != 2'd3) begin
                    phase_next = phase_reg + 2'd1;
                end else begin
                    phase_next = 2'd0;
                    if (hi_ok && (bit0 || bit1)) begin
                        code_next = {code_reg[CODE_W-2:0], !bit0};
                        bits_next = bits_reg + 7'd1;
                    end else begin
                        halted_next = 1'b1;
                    end
                end
            end

            res.bits = bits_next;
            if (!rep_next && !halted_next && bits_next >= cfg.target_bits) begin
                rep_next   = 1'b1;
                res.emit   = 1'b1;
                res.status = STATUS_OK;
                res.code   = code_next;
            end else if (last && !rep_next) begin
                res.emit   = 1'b1;
                res.status = STATUS_FAIL;
            end

            if (last) begin
                phase_next  = 2'd0;
                code_next   = '0;
                bits_next   = '0;
                halted_next = 1'b0;
                rep_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 2'd0;
            code_reg   <= '0;
            bits_reg   <= '0;
            halted_reg <= 1'b0;
            rep_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            bits_reg   <= bits_next;
            halted_reg <= halted_next;
            rep_reg    <= rep_next;
        end
    end

    // first three pulses of a group, always written before use
    always_ff @(posedge aclk) begin
        if (step && active && phase_reg != 2'd3) begin
            held_reg[phase_reg] <= pulse;
        end
    end

endmodule

### hdl/ook_four_pulse_bit_decoder.sv
// top level of the four-pulse ook bit decoder
//
// input channel s_*: one transfer per captured pulse, s_tdata carries the
// duration in microseconds and s_tlast marks the final pulse of a capture.
// result channel m_*: at most one transfer per pulse, a success result once
// the configured bit count is reached, or a failure result at the end of a
// capture that did not succeed.
// config port: cfg_we / cfg_index / cfg_wdata write one register per cycle,
// index 0 target bits, 1 short time, 2 long time, 3 tolerance percent,
// 4 protocol tag; write only between pulses, new values apply to the next one.
// a pulse is registered in the input register, then decoded into the result
// register that drives m_tvalid and m_tdata.
// throughput: one pulse per cycle while the receiver does not stall, limited
// by the single decode stage that updates the capture state for each pulse.
// reset (aresetn low, synchronous) restores register defaults and clears the
// capture state; both channels come up empty.
// when the receiver stalls the result waits in the output register; one more
// pulse is held in the input register, then s_tready drops.
module ook_four_pulse_bit_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_we,
    input  logic [ookd_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ookd_pkg::WDATA_W-1:0]  cfg_wdata,
    // pulse input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [15:0] pulse_us
    input  logic                          s_tlast,  // last_pulse
    // decode results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] status, [64:1] frame_code, [71:65] bit_total, [79:72] protocol_out
    output logic [79:0]                   m_tdata
);
    import ookd_pkg::*;

    cfg_t cfg;
    res_t res;

    logic               in_valid_reg;
    logic [PULSE_W-1:0] in_pulse_reg;
    logic               in_last_reg;
    logic               advance;
    logic               out_valid_reg;
    logic [79:0]        out_data_reg;

    ookd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // held pulse moves on when the output register has room for a result
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    ookd_dec u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_valid_reg && advance),
        .pulse   (in_pulse_reg),
        .last    (in_last_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pulse_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && res.emit) begin
            out_data_reg <= {res.tag, res.bits, res.code, res.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
